>>> design/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types and constants for the hex record line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  localparam int CharW  = 8;
  localparam int PosW   = 10;
  localparam int AddrW  = 16;
  localparam int ByteW  = 8;

  localparam logic [CharW-1:0] CharNewline = 8'd10;
  localparam logic [CharW-1:0] CharColon   = 8'h3a;
  localparam logic [CharW-1:0] CharZero    = 8'h30;
  localparam logic [CharW-1:0] CharNine    = 8'h39;
  localparam logic [CharW-1:0] CharUpperA  = 8'h41;

  localparam logic [PosW-1:0] PosMax       = 10'd1023;
  localparam logic [PosW-1:0] PosCountLo   = 10'd2;
  localparam logic [PosW-1:0] PosAddrHiLo  = 10'd4;
  localparam logic [PosW-1:0] PosAddrLoLo  = 10'd6;
  localparam logic [PosW-1:0] PosTypeHi    = 10'd7;
  localparam logic [PosW-1:0] PosTypeLo    = 10'd8;
  localparam logic [PosW-1:0] PosDataStart = 10'd10;

  typedef enum logic [0:0] {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } result_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_HEAD = 2'd1,
    STATUS_CHECKSUM = 2'd2,
    STATUS_SHORT    = 2'd3
  } line_status_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_HEAD = 2'd1,
    ERR_CHECKSUM = 2'd2
  } line_error_t;

  typedef struct packed {
    result_kind_t     kind;
    logic [AddrW-1:0] address;
    logic [ByteW-1:0] index;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] count;
    line_status_t     status;
  } result_t;

  // value of one hex digit character, modulo 256
  function automatic logic [ByteW-1:0] digit_value(input logic [CharW-1:0] c);
    if (c > CharNine) begin
      return c - CharUpperA + 8'd10;
    end
    return c - CharZero;
  endfunction

endpackage

>>> design/hrlp_in_reg.sv
// ----------------------------------------------------------------------------
// hrlp_in_reg
// Input register: holds one character until the parse stage takes it.
// ----------------------------------------------------------------------------
module hrlp_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [hrlp_pkg::CharW-1:0] line_char,
  input  logic                      advance,
  output logic                      hold_valid,
  output logic [hrlp_pkg::CharW-1:0] hold_char
);

  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_char <= line_char;
    end
  end

endmodule

>>> design/hrlp_step.sv
// ----------------------------------------------------------------------------
// hrlp_step
// Per-line parse state and the decode of one character into a result.
// ----------------------------------------------------------------------------
module hrlp_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [hrlp_pkg::CharW-1:0] char_in,
  output logic                       res_valid,
  output hrlp_pkg::result_t          res
);

  logic [hrlp_pkg::PosW-1:0]  char_position, char_position_next;
  logic [hrlp_pkg::ByteW-1:0] high_digit, high_digit_next;
  logic [hrlp_pkg::ByteW-1:0] running_sum, running_sum_next;
  logic [hrlp_pkg::ByteW-1:0] count_held, count_held_next;
  logic [hrlp_pkg::AddrW-1:0] address_held, address_held_next;
  hrlp_pkg::line_error_t      error_held, error_held_next;

  logic [hrlp_pkg::PosW-1:0]  cs_pos;
  logic [hrlp_pkg::PosW-1:0]  data_off;
  logic [hrlp_pkg::ByteW-1:0] digit;
  logic [hrlp_pkg::ByteW-1:0] pair;
  logic [hrlp_pkg::ByteW-1:0] sum;

  assign cs_pos   = hrlp_pkg::PosDataStart + {1'b0, count_held, 1'b0};
  assign data_off = char_position - hrlp_pkg::PosDataStart;
  assign digit    = hrlp_pkg::digit_value(char_in);
  assign pair     = {high_digit[3:0], 4'h0} + digit;
  assign sum      = running_sum + pair;

  always_comb begin
    char_position_next = char_position;
    high_digit_next    = high_digit;
    running_sum_next   = running_sum;
    count_held_next    = count_held;
    address_held_next  = address_held;
    error_held_next    = error_held;
    res_valid          = 1'b0;
    res.kind           = hrlp_pkg::KIND_DATA;
    res.address        = address_held;
    res.index          = data_off[8:1];
    res.data           = pair;
    res.count          = count_held;
    res.status         = hrlp_pkg::STATUS_OK;

    if (char_in == hrlp_pkg::CharNewline) begin
      res_valid  = 1'b1;
      res.kind   = hrlp_pkg::KIND_STATUS;
      res.index  = '0;
      res.data   = '0;
      if (error_held == hrlp_pkg::ERR_BAD_HEAD) begin
        res.status = hrlp_pkg::STATUS_BAD_HEAD;
      end else if (char_position <= cs_pos) begin
        res.status = hrlp_pkg::STATUS_SHORT;
      end else if (error_held == hrlp_pkg::ERR_CHECKSUM) begin
        res.status = hrlp_pkg::STATUS_CHECKSUM;
      end else begin
        res.status = hrlp_pkg::STATUS_OK;
      end
      char_position_next = '0;
      high_digit_next    = '0;
      running_sum_next   = '0;
      count_held_next    = '0;
      address_held_next  = '0;
      error_held_next    = hrlp_pkg::ERR_NONE;
    end else begin
      if (char_position != hrlp_pkg::PosMax) begin
        char_position_next = char_position + 1'b1;
      end
      if (error_held == hrlp_pkg::ERR_BAD_HEAD || char_position > cs_pos) begin
        // ignored character
      end else if (char_position == '0) begin
        if (char_in != hrlp_pkg::CharColon) begin
          error_held_next = hrlp_pkg::ERR_BAD_HEAD;
        end
      end else if (char_position == hrlp_pkg::PosTypeHi ||
                   char_position == hrlp_pkg::PosTypeLo) begin
        if (char_in != hrlp_pkg::CharZero) begin
          error_held_next = hrlp_pkg::ERR_BAD_HEAD;
        end
      end else if (char_position[0]) begin
        high_digit_next = digit;
      end else begin
        running_sum_next = sum;
        if (char_position == hrlp_pkg::PosCountLo) begin
          count_held_next = pair;
        end else if (char_position == hrlp_pkg::PosAddrHiLo) begin
          address_held_next = {pair, 8'h00};
        end else if (char_position == hrlp_pkg::PosAddrLoLo) begin
          address_held_next = {address_held[15:8], pair};
        end else if (char_position == cs_pos) begin
          if (sum != '0) begin
            error_held_next = hrlp_pkg::ERR_CHECKSUM;
          end
        end else begin
          res_valid = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      high_digit    <= '0;
      running_sum   <= '0;
      count_held    <= '0;
      address_held  <= '0;
      error_held    <= hrlp_pkg::ERR_NONE;
    end else if (advance) begin
      char_position <= char_position_next;
      high_digit    <= high_digit_next;
      running_sum   <= running_sum_next;
      count_held    <= count_held_next;
      address_held  <= address_held_next;
      error_held    <= error_held_next;
    end
  end

endmodule

>>> design/hrlp_out_reg.sv
// ----------------------------------------------------------------------------
// hrlp_out_reg
// Result register: holds one result until the downstream transfer.
// ----------------------------------------------------------------------------
module hrlp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hrlp_pkg::result_t res_in,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output hrlp_pkg::result_t res_out
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_out <= res_in;
    end
  end

endmodule

>>> design/hex_record_line_parser.sv
// ----------------------------------------------------------------------------
// hex_record_line_parser
// Parses data records of a hex text stream one character per transfer.
// ----------------------------------------------------------------------------
// One character is taken per cycle while the output does not stall: an
// input register feeds a single decode stage that updates the per-line state
// on each accepted character, and a result register carries the data byte or
// end-of-line status out; characters that give no result simply pass through
// the decode stage. Stalls on the output hold the input side after one
// buffered character.
module hex_record_line_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hrlp_pkg::CharW-1:0]  line_char,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        result_kind,
  output logic [hrlp_pkg::AddrW-1:0]  record_address,
  output logic [hrlp_pkg::ByteW-1:0]  byte_index,
  output logic [hrlp_pkg::ByteW-1:0]  data_byte,
  output logic [hrlp_pkg::ByteW-1:0]  byte_count,
  output logic [1:0]                  line_status
);

  logic                       hold_valid;
  logic [hrlp_pkg::CharW-1:0] hold_char;
  logic                       can_load;
  logic                       advance;
  logic                       res_valid;
  hrlp_pkg::result_t          res;
  hrlp_pkg::result_t          res_out;

  assign advance = hold_valid && can_load;

  hrlp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .line_char  (line_char),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_char  (hold_char)
  );

  hrlp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .char_in   (hold_char),
    .res_valid (res_valid),
    .res       (res)
  );

  hrlp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .res_in    (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign result_kind    = res_out.kind;
  assign record_address = res_out.address;
  assign byte_index     = res_out.index;
  assign data_byte      = res_out.data;
  assign byte_count     = res_out.count;
  assign line_status    = res_out.status;

endmodule
